// ===== design/kdlsp_pkg.sv =====
// Package for the key debounce / long-short press block.
// Holds register reset values, register indexes and the structs passed
// between modules. No dependencies.
`default_nettype none

package kdlsp_pkg;

    localparam int unsigned FilterW = 8;
    localparam int unsigned LongW   = 16;
    localparam int unsigned ApbAddrW = 3;
    localparam int unsigned ApbDataW = 32;

    localparam logic [FilterW-1:0] FilterReset = 8'd100;
    localparam logic [LongW-1:0]   LongReset   = 16'd700;
    localparam logic [LongW-1:0]   HoldMax     = 16'hFFFF;

    // Register indexes, taken from paddr[2].
    localparam logic RegFilter = 1'b0;
    localparam logic RegLong   = 1'b1;

    typedef struct packed {
        logic [FilterW-1:0] filter_ticks;
        logic [LongW-1:0]   long_ticks;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic press_kind;
    } t_event;

endpackage

`default_nettype wire

// ===== design/kdlsp_key_if.sv =====
// Stream interface for the sampled key level (one word per timer tick).
// No dependencies.
`default_nettype none

interface kdlsp_key_if;
    logic valid;
    logic ready;
    logic key_level;

    modport source (output valid, output key_level, input ready);
    modport sink   (input valid, input key_level, output ready);
endinterface

`default_nettype wire

// ===== design/kdlsp_event_if.sv =====
// Stream interface for judged press events (0 short, 1 long).
// No dependencies.
`default_nettype none

interface kdlsp_event_if;
    logic valid;
    logic ready;
    logic press_kind;

    modport source (output valid, output press_kind, input ready);
    modport sink   (input valid, input press_kind, output ready);
endinterface

`default_nettype wire

// ===== design/kdlsp_cfg.sv =====
// APB register block for filter_ticks and long_ticks.
// Depends on kdlsp_pkg.
`default_nettype none

module kdlsp_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [kdlsp_pkg::ApbAddrW-1:0] paddr,
    input  wire logic [kdlsp_pkg::ApbDataW-1:0] pwdata,
    output      logic [kdlsp_pkg::ApbDataW-1:0] prdata,
    output      logic                          pready,
    output      kdlsp_pkg::t_cfg               o_cfg
);
    import kdlsp_pkg::*;

    logic [FilterW-1:0] r_filter_ticks;
    logic [LongW-1:0]   r_long_ticks;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_ticks <= FilterReset;
            r_long_ticks   <= LongReset;
        end else if (w_wr) begin
            case (paddr[2])
                RegFilter: r_filter_ticks <= pwdata[FilterW-1:0];
                RegLong:   r_long_ticks   <= pwdata[LongW-1:0];
                default:   r_filter_ticks <= r_filter_ticks;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            RegFilter: prdata = {{(ApbDataW-FilterW){1'b0}}, r_filter_ticks};
            RegLong:   prdata = {{(ApbDataW-LongW){1'b0}}, r_long_ticks};
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.filter_ticks = r_filter_ticks;
    assign o_cfg.long_ticks   = r_long_ticks;

endmodule

`default_nettype wire

// ===== design/kdlsp_core.sv =====
// Debounce and press judgement: state registers and their one-tick update.
// Depends on kdlsp_pkg.
`default_nettype none

module kdlsp_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic             i_key_level,
    input  wire kdlsp_pkg::t_cfg  i_cfg,
    output      kdlsp_pkg::t_event o_event
);
    import kdlsp_pkg::*;

    logic [FilterW-1:0] r_press_cnt,   n_press_cnt;
    logic [FilterW-1:0] r_release_cnt, n_release_cnt;
    logic               r_key_held,    n_key_held;
    logic               r_long_flag,   n_long_flag;
    logic               r_judging,     n_judging;
    logic               r_judged,      n_judged;
    logic [LongW-1:0]   r_hold_cnt,    n_hold_cnt;

    logic               w_low;
    logic [FilterW-1:0] w_press_dec;
    logic [FilterW-1:0] w_release_dec;
    logic [LongW-1:0]   w_hold_inc;

    assign w_low         = !i_key_level;
    assign w_press_dec   = r_press_cnt - 1'b1;
    assign w_release_dec = r_release_cnt - 1'b1;
    assign w_hold_inc    = (r_hold_cnt == HoldMax) ? r_hold_cnt : r_hold_cnt + 1'b1;

    always_comb begin
        n_press_cnt   = r_press_cnt;
        n_release_cnt = r_release_cnt;
        n_key_held    = r_key_held;
        n_long_flag   = r_long_flag;
        n_judging     = r_judging;
        n_judged      = r_judged;
        n_hold_cnt    = r_hold_cnt;
        o_event.valid      = 1'b0;
        o_event.press_kind = r_long_flag;

        if (i_accept) begin
            if (!r_judging && !r_judged) begin
                if (!r_key_held) begin
                    n_release_cnt = i_cfg.filter_ticks;
                    if (w_low) begin
                        n_press_cnt = w_press_dec;
                        if (w_press_dec == '0) begin
                            n_key_held  = 1'b1;
                            n_long_flag = 1'b0;
                            n_hold_cnt  = '0;
                            n_judging   = 1'b1;
                            n_press_cnt = i_cfg.filter_ticks;
                        end
                    end else begin
                        n_press_cnt = i_cfg.filter_ticks;
                    end
                end else begin
                    n_press_cnt = i_cfg.filter_ticks;
                    if (!w_low) begin
                        n_release_cnt = w_release_dec;
                        if (w_release_dec == '0) begin
                            n_key_held = 1'b0;
                        end
                    end else begin
                        n_release_cnt = i_cfg.filter_ticks;
                    end
                end
            end else if (r_judging) begin
                if (w_low) begin
                    n_hold_cnt = w_hold_inc;
                    if (w_hold_inc >= i_cfg.long_ticks) begin
                        n_long_flag = 1'b1;
                        n_judging   = 1'b0;
                        n_judged    = 1'b1;
                    end
                end else begin
                    n_judging = 1'b0;
                    n_judged  = 1'b1;
                end
            end else begin
                // The tick after judgement only reports the event.
                n_judged      = 1'b0;
                o_event.valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_cnt   <= FilterReset;
            r_release_cnt <= FilterReset;
            r_key_held    <= 1'b0;
            r_long_flag   <= 1'b0;
            r_judging     <= 1'b0;
            r_judged      <= 1'b0;
            r_hold_cnt    <= '0;
        end else begin
            r_press_cnt   <= n_press_cnt;
            r_release_cnt <= n_release_cnt;
            r_key_held    <= n_key_held;
            r_long_flag   <= n_long_flag;
            r_judging     <= n_judging;
            r_judged      <= n_judged;
            r_hold_cnt    <= n_hold_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== design/kdlsp_out_buf.sv =====
// Two-word result buffer between the judgement logic and the event channel.
// Depends on kdlsp_pkg.
`default_nettype none

module kdlsp_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kdlsp_pkg::t_event i_event,
    output      logic              o_room,
    output      logic              o_valid,
    output      logic              o_press_kind,
    input  wire logic              i_ready
);
    import kdlsp_pkg::*;

    logic [1:0] r_mem;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_push;
    logic       w_pop;

    assign w_push       = i_event.valid;
    assign w_pop        = o_valid && i_ready;
    assign o_valid      = (r_count != 2'd0);
    assign o_room       = (r_count != 2'd2);
    assign o_press_kind = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_event.press_kind;
        end
    end

endmodule

`default_nettype wire

// ===== design/key_debounce_long_short_press_unit.sv =====
// Key debounce with long/short press judgement. Each key word is one sampled,
// active-low key level per timer tick; after filter_ticks low samples a press
// is taken, it is judged long once long_ticks held ticks are seen, short if
// released first, and the word after judgement yields one press_kind event.
// The block takes one key word per clock cycle; the state update is combinational
// logic ahead of the state registers. Events go through a two-word buffer, so key
// words are only held off while two events wait to be taken on the event channel.
// Depends on kdlsp_pkg, kdlsp_key_if, kdlsp_event_if, kdlsp_cfg, kdlsp_core,
// kdlsp_out_buf.
`default_nettype none

module key_debounce_long_short_press_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    kdlsp_key_if.sink                           i_key,
    kdlsp_event_if.source                       o_event,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [kdlsp_pkg::ApbAddrW-1:0] paddr,
    input  wire logic [kdlsp_pkg::ApbDataW-1:0] pwdata,
    output      logic [kdlsp_pkg::ApbDataW-1:0] prdata,
    output      logic                           pready
);
    import kdlsp_pkg::*;

    t_cfg   w_cfg;
    t_event w_event;
    logic   w_room;
    logic   w_accept;

    assign i_key.ready = w_room;
    assign w_accept    = i_key.valid && w_room;

    kdlsp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    kdlsp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_key_level (i_key.key_level),
        .i_cfg       (w_cfg),
        .o_event     (w_event)
    );

    kdlsp_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_event      (w_event),
        .o_room       (w_room),
        .o_valid      (o_event.valid),
        .o_press_kind (o_event.press_kind),
        .i_ready      (o_event.ready)
    );

    // An event is only produced by an accepted key word.
    a_event_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_event.valid |-> w_accept)
        else $error("event produced without an accepted key word");

    // Key words are only held off while buffered events wait.
    a_stall_means_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_key.ready |-> o_event.valid)
        else $error("key channel stalled with no pending event");

    // A produced event is visible on the event channel next cycle.
    a_event_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_event.valid |=> o_event.valid)
        else $error("produced event not presented");

endmodule

`default_nettype wire

// ===== sim/tb_key_debounce_long_short_press_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for key_debounce_long_short_press_unit: predicts press events from
// the accepted key words and checks them in order. Depends on kdlsp_pkg and the interfaces.

import kdlsp_pkg::*;

typedef enum bit {
    PRESS_SHORT = 1'b0,
    PRESS_LONG  = 1'b1
} press_kind_e;

class press_event_checker;
    logic [FilterW-1:0] filter;
    logic [LongW-1:0]   long_lim;
    logic [FilterW-1:0] press_cnt;
    logic [FilterW-1:0] release_cnt;
    logic [LongW-1:0]   hold_cnt;
    bit                 held;
    bit                 long_press;
    bit                 judging;
    bit                 judged;
    press_kind_e        pending_kinds[$];
    int                 keys_seen;
    int                 kinds_predicted;
    int                 errors;

    function new();
        filter          = FilterReset;
        long_lim        = LongReset;
        press_cnt       = FilterReset;
        release_cnt     = FilterReset;
        hold_cnt        = '0;
        held            = 1'b0;
        long_press      = 1'b0;
        judging         = 1'b0;
        judged          = 1'b0;
        keys_seen       = 0;
        kinds_predicted = 0;
        errors          = 0;
    endfunction

    function void report(string msg);
        errors++;
        if (errors <= 10) begin
            $display("[%0t] %s", $time, msg);
        end
    endfunction

    // Counters keep their values across a register write; filter applies at reload, long_lim at once.
    function void set_reg(logic idx, logic [31:0] value);
        if (idx == RegFilter) begin
            filter = value[FilterW-1:0];
        end else begin
            long_lim = value[LongW-1:0];
        end
    endfunction

    function void take_key_tick(logic level);
        bit low;
        low = (level == 1'b0);
        keys_seen++;
        if (!judging && !judged) begin
            if (!held) begin
                release_cnt = filter;
                if (low) begin
                    press_cnt = press_cnt - 8'd1;
                    if (press_cnt == 0) begin
                        held       = 1'b1;
                        long_press = 1'b0;
                        hold_cnt   = '0;
                        judging    = 1'b1;
                        press_cnt  = filter;
                    end
                end else begin
                    press_cnt = filter;
                end
            end else begin
                press_cnt = filter;
                if (!low) begin
                    release_cnt = release_cnt - 8'd1;
                    if (release_cnt == 0) begin
                        held = 1'b0;
                    end
                end else begin
                    release_cnt = filter;
                end
            end
        end else if (judging) begin
            if (low) begin
                if (hold_cnt != HoldMax) begin
                    hold_cnt = hold_cnt + 16'd1;
                end
                if (hold_cnt >= long_lim) begin
                    long_press = 1'b1;
                    judging    = 1'b0;
                    judged     = 1'b1;
                end
            end else begin
                judging = 1'b0;
                judged  = 1'b1;
            end
        end else begin
            // The word after the judgement carries the event out, whatever its level.
            judged = 1'b0;
            pending_kinds.push_back(long_press ? PRESS_LONG : PRESS_SHORT);
            kinds_predicted++;
        end
    endfunction

    function void match_event(logic kind);
        press_kind_e want;
        if (pending_kinds.size() == 0) begin
            report($sformatf("unexpected press event, press_kind %0d", kind));
        end else begin
            want = pending_kinds.pop_front();
            if (kind !== logic'(want)) begin
                report($sformatf("press_kind mismatch: expected %0d, got %0d", want, kind));
            end
        end
    endfunction

    function int pending();
        return pending_kinds.size();
    endfunction
endclass

module tb_key_debounce_long_short_press_unit;

    typedef enum int {
        SEQ_ANY,
        SEQ_LONG,
        SEQ_SHORT
    } press_seq_e;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    press_event_checker sb;

    kdlsp_key_if   key_if ();
    kdlsp_event_if ev_if ();

    key_debounce_long_short_press_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_if),
        .o_event (ev_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        ev_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            ev_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Events are checked before the key word of the same edge is noted, so an event can
    // never be matched against an expectation raised at that very edge.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (ev_if.valid === 1'b1 && ev_if.ready === 1'b1) begin
                sb.match_event(ev_if.press_kind);
            end
            if (key_if.valid === 1'b1 && key_if.ready === 1'b1) begin
                sb.take_key_tick(key_if.key_level);
            end
        end
    end

    task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic idx, input logic [31:0] want);
        logic [31:0] rd;
        logic [31:0] mask;
        apb_access(1'b0, idx, '0, rd);
        mask = (idx == RegFilter) ? 32'h0000_00FF : 32'h0000_FFFF;
        if ((rd & mask) !== (want & mask)) begin
            sb.report($sformatf("register %0d readback: expected %0h, got %0h",
                                idx, want & mask, rd & mask));
        end
    endtask

    task automatic set_reg(input logic idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, idx, value, rd);
        sb.set_reg(idx, value);
        check_reg(idx, value);
    endtask

    task automatic send_tick(input logic level);
        key_if.valid     <= 1'b1;
        key_if.key_level <= level;
        do @(posedge i_clk); while (key_if.ready !== 1'b1);
        while ($urandom_range(99) < sender_idle_pct) begin
            key_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_pattern(input logic [31:0] pat, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            send_tick(pat[i]);
        end
    endtask

    // Lets the block drain: all events taken, then an idle wait for words that raise none.
    task automatic settle_block();
        key_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // One press with random content: optional bounce on the way down, the debounce, a hold
    // of the chosen length, the event word, then a release that may bounce as well.
    task automatic press_seq(input press_seq_e mode);
        int f;
        int lim;
        int cap;
        int h;
        f   = (sb.filter == 0) ? 256 : int'(sb.filter);
        lim = (sb.long_lim == 0) ? 1 : int'(sb.long_lim);
        cap = (lim > 16) ? 16 : lim;
        repeat ($urandom_range(0, 2)) send_tick(1'b1);
        if (mode == SEQ_ANY && $urandom_range(4) == 0) begin
            repeat ($urandom_range(1, f)) send_tick(1'b0);
            send_tick(1'b1);
        end
        repeat (f) send_tick(1'b0);
        case (mode)
            SEQ_LONG: begin
                h = lim;
            end
            SEQ_SHORT: begin
                h = $urandom_range(0, cap - 1);
            end
            default: begin
                h = $urandom_range(0, cap);
            end
        endcase
        repeat (h) send_tick(1'b0);
        if (h < lim) begin
            send_tick(1'b1);
        end
        send_tick(1'($urandom_range(1)));
        repeat ($urandom_range(0, 2)) send_tick(1'b0);
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, f)) send_tick(1'b1);
            send_tick(1'b0);
        end
        repeat (f + $urandom_range(0, 2)) send_tick(1'b1);
    endtask

    initial begin
        int          base_keys;
        int          base_kinds;
        logic [7:0]  f_set;
        logic [15:0] l_set;
        sb = new();
        i_rst_n          <= 1'b0;
        key_if.valid     <= 1'b0;
        key_if.key_level <= 1'b1;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_reg(RegFilter, 32'(FilterReset));
        check_reg(RegLong, 32'(LongReset));

        // A press that bounces on the way down and is judged short, then a long press.
        set_reg(RegFilter, 32'd2);
        set_reg(RegLong, 32'd3);
        send_pattern(32'b101000111100000011, 18);
        settle_block();
        // A zero long time judges long after one held tick.
        set_reg(RegLong, 32'd0);
        send_pattern(32'b000111, 6);
        settle_block();

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 75 : 0;
            recv_stall_pct  = (phase == 0) ? 75 : (phase == 1) ? 9 : 0;
            base_keys  = sb.keys_seen;
            base_kinds = sb.kinds_predicted;
            for (int s = 0; s < 4; s++) begin
                settle_block();
                if (s == 3) begin
                    case (phase)
                        0: begin
                            f_set = 8'd1;
                            l_set = 16'd0;
                        end
                        1: begin
                            f_set = 8'd8;
                            l_set = 16'd1;
                        end
                        default: begin
                            f_set = 8'd3;
                            l_set = 16'd24;
                        end
                    endcase
                end else begin
                    f_set = 8'($urandom_range(1, 4));
                    l_set = 16'($urandom_range(0, 10));
                end
                set_reg(RegFilter, 32'(f_set));
                set_reg(RegLong, 32'(l_set));
                if (s == 3) begin
                    press_seq(SEQ_LONG);
                    press_seq(SEQ_SHORT);
                end else begin
                    while (sb.keys_seen - base_keys < (s + 1) * 45
                           || sb.kinds_predicted - base_kinds < (s + 1) * 2) begin
                        if ($urandom_range(9) < 2) begin
                            repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)));
                        end else begin
                            press_seq(SEQ_ANY);
                        end
                    end
                end
            end
        end

        settle_block();
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

endmodule
